@@ src/buddy_allocator_unit_macros.svh @@
// ============================================================================
// Buddy allocator assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ============================================================================
`ifndef BUDDY_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/bau_pkg.sv @@
// ============================================================================
// Buddy allocator package
// Types and constants shared by the allocator modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
package bau_pkg;

    localparam int UNIT_BITS  = 11;
    localparam int LINK_BITS  = 12;
    localparam int LVL_BITS   = 3;
    localparam int LEVELS     = 8;
    localparam int HDR_BITS   = 4;
    localparam int UNITS      = 2048;

    localparam logic [LINK_BITS-1:0] NIL       = 12'hFFF;
    localparam logic [LVL_BITS-1:0]  TOP_LEVEL = 3'd7;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE   = 2'd1;
    localparam logic [1:0] ST_NO_MEMORY   = 2'd2;
    localparam logic [1:0] ST_DOUBLE_FREE = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_AUNL  = 9'b000000010,
        S_SPLIT = 9'b000000100,
        S_PUSH  = 9'b000001000,
        S_PUSHP = 9'b000010000,
        S_FCHK  = 9'b000100000,
        S_MRD   = 9'b001000000,
        S_MCHK  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

endpackage
`default_nettype wire

@@ src/buddy_allocator_unit.sv @@
// Alloc: unlink a block from a free list or take a new chunk, then split it down one level per step.
// Free: check the header, then merge with the buddy level by level over up to seven levels, then push.
// Errors end the transaction early; a stalled result port adds its stall; one transaction at a time.
// The header and link memories, one read and one write port each, set the step rate.
// Reset clears the free list heads, the chunk count and the control state;
// memory contents are not cleared and are written before they are read.
// ============================================================================
// Buddy allocator unit
// Binary buddy allocator over 16-byte units with eight block levels.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_allocator_unit_macros.svh"
module buddy_allocator_unit #(
    parameter int HEAP_CHUNKS  = 16,
    parameter int HEADER_BYTES = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [15:0] request_bytes,
    input  wire logic [14:0] free_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [14:0]      address,
    output logic [1:0]       status
);

    localparam int CHUNK_LIMIT = (HEAP_CHUNKS < 16) ? HEAP_CHUNKS : 16;

    bau_pkg::state_t state_reg, state_next;

    logic [bau_pkg::LINK_BITS-1:0] heads_reg [bau_pkg::LEVELS];
    logic [bau_pkg::LINK_BITS-1:0] heads_next [bau_pkg::LEVELS];
    logic [4:0]                    chunks_reg, chunks_next;
    logic [bau_pkg::UNIT_BITS-1:0] cur_reg, cur_next;
    logic [bau_pkg::UNIT_BITS-1:0] bud_reg, bud_next;
    logic [bau_pkg::UNIT_BITS-1:0] pu_reg, pu_next;
    logic [bau_pkg::LVL_BITS-1:0]  pl_reg, pl_next;
    logic [bau_pkg::LVL_BITS-1:0]  lvl_reg, lvl_next;
    logic [bau_pkg::LVL_BITS-1:0]  want_reg, want_next;
    logic [bau_pkg::LINK_BITS-1:0] h_reg, h_next;
    logic                          alloc_reg, alloc_next;
    logic [1:0]                    res_st_reg, res_st_next;
    logic [14:0]                   res_addr_reg, res_addr_next;
    logic                          ov_reg, ov_next;
    logic [14:0]                   oaddr_reg, oaddr_next;
    logic [1:0]                    ost_reg, ost_next;

    logic [bau_pkg::UNIT_BITS-1:0] raddr;
    logic                          hdr_we, nxt_we, prv_we;
    logic [bau_pkg::UNIT_BITS-1:0] hdr_wa, nxt_wa, prv_wa;
    logic [bau_pkg::HDR_BITS-1:0]  hdr_wd, hdr_rd;
    logic [bau_pkg::LINK_BITS-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd;

    logic                          accept;
    logic [16:0]                   total;
    logic [bau_pkg::LVL_BITS-1:0]  want_c, found_lvl;
    logic                          found;
    logic [14:0]                   start;
    logic [bau_pkg::UNIT_BITS-1:0] step_bit;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != bau_pkg::S_IDLE);
    assign total    = {1'b0, request_bytes} + 17'(HEADER_BYTES);
    assign start    = free_address - 15'(HEADER_BYTES);
    assign step_bit = bau_pkg::UNIT_BITS'(1) << lvl_reg;

    always_comb
    begin
        want_c = bau_pkg::TOP_LEVEL;
        for (int w = 7; w >= 0; w--)
        begin
            if (total <= (17'd16 << w))
            begin
                want_c = bau_pkg::LVL_BITS'(w);
            end
        end
        found     = 1'b0;
        found_lvl = '0;
        for (int l = 7; l >= 0; l--)
        begin
            if (bau_pkg::LVL_BITS'(l) >= want_c && heads_reg[l] != bau_pkg::NIL)
            begin
                found     = 1'b1;
                found_lvl = bau_pkg::LVL_BITS'(l);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        chunks_next   = chunks_reg;
        cur_next      = cur_reg;
        bud_next      = bud_reg;
        pu_next       = pu_reg;
        pl_next       = pl_reg;
        lvl_next      = lvl_reg;
        want_next     = want_reg;
        h_next        = h_reg;
        alloc_next    = alloc_reg;
        res_st_next   = res_st_reg;
        res_addr_next = res_addr_reg;
        ov_next       = ov_reg;
        oaddr_next    = oaddr_reg;
        ost_next      = ost_reg;
        for (int i = 0; i < bau_pkg::LEVELS; i++)
        begin
            heads_next[i] = heads_reg[i];
        end
        raddr  = cur_reg;
        hdr_we = 1'b0;
        hdr_wa = cur_reg;
        hdr_wd = '0;
        nxt_we = 1'b0;
        nxt_wa = cur_reg;
        nxt_wd = '0;
        prv_we = 1'b0;
        prv_wa = cur_reg;
        prv_wd = '0;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            bau_pkg::S_IDLE:
            begin
                res_addr_next = '0;
                res_st_next   = bau_pkg::ST_OK;
                if (op == bau_pkg::OP_ALLOC)
                begin
                    raddr = heads_reg[found_lvl][bau_pkg::UNIT_BITS-1:0];
                end
                else
                begin
                    raddr = start[14:4];
                end
                if (accept)
                begin
                    alloc_next = (op == bau_pkg::OP_ALLOC);
                    want_next  = want_c;
                    if (op == bau_pkg::OP_ALLOC)
                    begin
                        if (total > 17'd2048)
                        begin
                            res_st_next = bau_pkg::ST_TOO_LARGE;
                            state_next  = bau_pkg::S_DONE;
                        end
                        else if (found)
                        begin
                            cur_next   = heads_reg[found_lvl][bau_pkg::UNIT_BITS-1:0];
                            lvl_next   = found_lvl;
                            state_next = bau_pkg::S_AUNL;
                        end
                        else if (chunks_reg >= 5'(CHUNK_LIMIT))
                        begin
                            res_st_next = bau_pkg::ST_NO_MEMORY;
                            state_next  = bau_pkg::S_DONE;
                        end
                        else
                        begin
                            cur_next    = {chunks_reg[3:0], 7'd0};
                            chunks_next = chunks_reg + 5'd1;
                            lvl_next    = bau_pkg::TOP_LEVEL;
                            state_next  = bau_pkg::S_SPLIT;
                        end
                    end
                    else if (free_address < 15'(HEADER_BYTES) || start[3:0] != 4'd0)
                    begin
                        res_st_next = bau_pkg::ST_DOUBLE_FREE;
                        state_next  = bau_pkg::S_DONE;
                    end
                    else
                    begin
                        cur_next   = start[14:4];
                        state_next = bau_pkg::S_FCHK;
                    end
                end
            end
            bau_pkg::S_AUNL:
            begin
                heads_next[lvl_reg] = nxt_rd;
                if (nxt_rd != bau_pkg::NIL)
                begin
                    prv_we = 1'b1;
                    prv_wa = nxt_rd[bau_pkg::UNIT_BITS-1:0];
                    prv_wd = prv_rd;
                end
                hdr_we     = 1'b1;
                hdr_wd     = {1'b1, lvl_reg};
                state_next = bau_pkg::S_SPLIT;
            end
            bau_pkg::S_SPLIT:
            begin
                if (lvl_reg > want_reg)
                begin
                    lvl_next   = lvl_reg - 3'd1;
                    pl_next    = lvl_reg - 3'd1;
                    pu_next    = cur_reg + (bau_pkg::UNIT_BITS'(1) << (lvl_reg - 3'd1));
                    state_next = bau_pkg::S_PUSH;
                end
                else
                begin
                    hdr_we        = 1'b1;
                    hdr_wd        = {1'b1, want_reg};
                    res_addr_next = {cur_reg, 4'd0} + 15'(HEADER_BYTES);
                    res_st_next   = bau_pkg::ST_OK;
                    state_next    = bau_pkg::S_DONE;
                end
            end
            bau_pkg::S_PUSH:
            begin
                h_next  = heads_reg[pl_reg];
                hdr_we  = 1'b1;
                hdr_wa  = pu_reg;
                hdr_wd  = {1'b0, pl_reg};
                nxt_we  = 1'b1;
                nxt_wa  = pu_reg;
                nxt_wd  = heads_reg[pl_reg];
                prv_we  = 1'b1;
                prv_wa  = pu_reg;
                prv_wd  = bau_pkg::NIL;
                heads_next[pl_reg] = {1'b0, pu_reg};
                if (heads_reg[pl_reg] != bau_pkg::NIL)
                begin
                    state_next = bau_pkg::S_PUSHP;
                end
                else if (alloc_reg)
                begin
                    state_next = bau_pkg::S_SPLIT;
                end
                else
                begin
                    state_next = bau_pkg::S_DONE;
                end
            end
            bau_pkg::S_PUSHP:
            begin
                prv_we     = 1'b1;
                prv_wa     = h_reg[bau_pkg::UNIT_BITS-1:0];
                prv_wd     = {1'b0, pu_reg};
                state_next = alloc_reg ? bau_pkg::S_SPLIT : bau_pkg::S_DONE;
            end
            bau_pkg::S_FCHK:
            begin
                if (!hdr_rd[3])
                begin
                    res_st_next = bau_pkg::ST_DOUBLE_FREE;
                    state_next  = bau_pkg::S_DONE;
                end
                else
                begin
                    hdr_we   = 1'b1;
                    hdr_wd   = {1'b0, hdr_rd[2:0]};
                    lvl_next = hdr_rd[2:0];
                    pu_next  = cur_reg;
                    pl_next  = hdr_rd[2:0];
                    state_next = (hdr_rd[2:0] < bau_pkg::TOP_LEVEL) ?
                                 bau_pkg::S_MRD : bau_pkg::S_PUSH;
                end
            end
            bau_pkg::S_MRD:
            begin
                raddr      = cur_reg ^ step_bit;
                bud_next   = cur_reg ^ step_bit;
                state_next = bau_pkg::S_MCHK;
            end
            bau_pkg::S_MCHK:
            begin
                if (hdr_rd[3] || hdr_rd[2:0] != lvl_reg)
                begin
                    pu_next    = cur_reg;
                    pl_next    = lvl_reg;
                    state_next = bau_pkg::S_PUSH;
                end
                else
                begin
                    if (heads_reg[lvl_reg] == {1'b0, bud_reg})
                    begin
                        heads_next[lvl_reg] = nxt_rd;
                    end
                    else if (prv_rd != bau_pkg::NIL)
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = prv_rd[bau_pkg::UNIT_BITS-1:0];
                        nxt_wd = nxt_rd;
                    end
                    if (nxt_rd != bau_pkg::NIL)
                    begin
                        prv_we = 1'b1;
                        prv_wa = nxt_rd[bau_pkg::UNIT_BITS-1:0];
                        prv_wd = prv_rd;
                    end
                    hdr_we   = 1'b1;
                    hdr_wa   = bud_reg;
                    hdr_wd   = {1'b0, lvl_reg};
                    cur_next = cur_reg & ~step_bit;
                    lvl_next = lvl_reg + 3'd1;
                    pu_next  = cur_reg & ~step_bit;
                    pl_next  = lvl_reg + 3'd1;
                    state_next = (lvl_reg + 3'd1 < bau_pkg::TOP_LEVEL) ?
                                 bau_pkg::S_MRD : bau_pkg::S_PUSH;
                end
            end
            bau_pkg::S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    oaddr_next = res_addr_reg;
                    ost_next   = res_st_reg;
                    state_next = bau_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bau_pkg::S_IDLE;
            chunks_reg <= '0;
            ov_reg     <= 1'b0;
            alloc_reg  <= 1'b0;
            for (int i = 0; i < bau_pkg::LEVELS; i++)
            begin
                heads_reg[i] <= bau_pkg::NIL;
            end
        end
        else
        begin
            state_reg  <= state_next;
            chunks_reg <= chunks_next;
            ov_reg     <= ov_next;
            alloc_reg  <= alloc_next;
            for (int i = 0; i < bau_pkg::LEVELS; i++)
            begin
                heads_reg[i] <= heads_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        bud_reg      <= bud_next;
        pu_reg       <= pu_next;
        pl_reg       <= pl_next;
        lvl_reg      <= lvl_next;
        want_reg     <= want_next;
        h_reg        <= h_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        oaddr_reg    <= oaddr_next;
        ost_reg      <= ost_next;
    end

    bau_ram #(.WIDTH(bau_pkg::HDR_BITS), .DEPTH(bau_pkg::UNITS)) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_wa),
        .wdata (hdr_wd),
        .raddr (raddr),
        .rdata (hdr_rd)
    );

    bau_ram #(.WIDTH(bau_pkg::LINK_BITS), .DEPTH(bau_pkg::UNITS)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_wa),
        .wdata (nxt_wd),
        .raddr (raddr),
        .rdata (nxt_rd)
    );

    bau_ram #(.WIDTH(bau_pkg::LINK_BITS), .DEPTH(bau_pkg::UNITS)) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_wa),
        .wdata (prv_wd),
        .raddr (raddr),
        .rdata (prv_rd)
    );

    assign out_valid = ov_reg;
    assign address   = oaddr_reg;
    assign status    = ost_reg;

    `BAU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, state_reg != bau_pkg::S_IDLE)
    `BAU_ASSERT_IMPL(a_addr_only_ok, clk, rst_n, ov_reg && oaddr_reg != 15'd0, ost_reg == bau_pkg::ST_OK)
    `BAU_ASSERT_IMPL(a_chunk_bound, clk, rst_n, 1'b1, chunks_reg <= 5'(CHUNK_LIMIT))
    `BAU_ASSERT_IMPL(a_split_order, clk, rst_n, state_reg == bau_pkg::S_SPLIT, lvl_reg >= want_reg)

endmodule
`default_nettype wire

@@ src/bau_ram.sv @@
// ============================================================================
// Buddy allocator RAM
// Generic single-write, single-read memory with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module bau_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ tb/buddy_allocator_unit_test.sv @@
// ============================================================================
// Buddy allocator unit testbench
// Drives allocate and free transactions through the valid/stall handshake and
// checks every result against a behavioral buddy allocator with its own free
// lists, headers and chunk count. A directed table covers size extremes,
// oversize requests, misaligned and double frees; full-chunk requests exhaust
// the heap, frees give full merges, and random alloc/free traffic follows.
// ============================================================================
`timescale 1ns / 1ps
module buddy_allocator_unit_test;

    localparam int HDR    = 12;
    localparam int CHUNKS = 16;
    localparam int NUM_RANDOM = 600;

    typedef struct packed {
        logic        op;
        logic [15:0] req;
        logic [14:0] addr;
        logic        chk;
        logic [14:0] exp_addr;
        logic [1:0]  exp_status;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic op;
    logic [15:0] request_bytes;
    logic [14:0] free_address;
    logic out_valid;
    logic out_stall;
    logic [14:0] address;
    logic [1:0] status;

    buddy_allocator_unit #(.HEAP_CHUNKS(CHUNKS), .HEADER_BYTES(HDR)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .request_bytes(request_bytes), .free_address(free_address),
        .out_valid(out_valid), .out_stall(out_stall), .address(address),
        .status(status)
    );

    logic [2:0]  hdr_level [bau_pkg::UNITS];
    logic        hdr_used  [bau_pkg::UNITS];
    logic        hdr_known [bau_pkg::UNITS];
    logic [11:0] link_next [bau_pkg::UNITS];
    logic [11:0] link_prev [bau_pkg::UNITS];
    logic [11:0] free_head [bau_pkg::LEVELS];
    int          chunk_count;

    logic [14:0] expected_addr[$];
    logic [1:0]  expected_status[$];
    logic [14:0] live_blocks[$];
    int mismatches;
    bit calm;

    function automatic void list_push(int u, int lvl);
        hdr_level[u] = 3'(lvl);
        hdr_used[u] = 1'b0;
        hdr_known[u] = 1'b1;
        link_next[u] = free_head[lvl];
        if (free_head[lvl] != bau_pkg::NIL)
            link_prev[free_head[lvl][10:0]] = 12'(u);
        link_prev[u] = bau_pkg::NIL;
        free_head[lvl] = 12'(u);
    endfunction

    function automatic void list_unlink(int u, int lvl);
        logic [11:0] nx;
        logic [11:0] pv;
        nx = link_next[u];
        pv = link_prev[u];
        if (free_head[lvl] == 12'(u))
            free_head[lvl] = nx;
        else if (pv != bau_pkg::NIL)
            link_next[pv[10:0]] = nx;
        if (nx != bau_pkg::NIL)
            link_prev[nx[10:0]] = pv;
        hdr_used[u] = 1'b1;
    endfunction

    function automatic void heap_step(input logic o, input logic [15:0] req,
                                      input logic [14:0] fa_in,
                                      output logic [14:0] ra, output logic [1:0] rs);
        int total;
        int want;
        int lvl;
        int u;
        int b;
        int start;
        ra = '0;
        rs = bau_pkg::ST_OK;
        if (o == bau_pkg::OP_ALLOC)
        begin
            total = int'(req) + HDR;
            if (total > 2048)
            begin
                rs = bau_pkg::ST_TOO_LARGE;
                return;
            end
            want = 0;
            while (want < 7 && (16 << want) < total)
                want++;
            lvl = want;
            while (lvl < bau_pkg::LEVELS && free_head[lvl] == bau_pkg::NIL)
                lvl++;
            if (lvl < bau_pkg::LEVELS)
            begin
                u = int'(free_head[lvl][10:0]);
                list_unlink(u, lvl);
            end
            else
            begin
                if (chunk_count >= CHUNKS)
                begin
                    rs = bau_pkg::ST_NO_MEMORY;
                    return;
                end
                u = chunk_count * 128;
                chunk_count++;
                lvl = 7;
            end
            while (lvl > want)
            begin
                lvl--;
                list_push(u + (1 << lvl), lvl);
            end
            hdr_level[u] = 3'(want);
            hdr_used[u] = 1'b1;
            hdr_known[u] = 1'b1;
            ra = 15'((u << 4) + HDR);
        end
        else
        begin
            if (int'(fa_in) < HDR)
            begin
                rs = bau_pkg::ST_DOUBLE_FREE;
                return;
            end
            start = int'(fa_in) - HDR;
            if (start % 16 != 0)
            begin
                rs = bau_pkg::ST_DOUBLE_FREE;
                return;
            end
            u = (start >> 4) & 32'h7FF;
            if (!hdr_used[u])
            begin
                rs = bau_pkg::ST_DOUBLE_FREE;
                return;
            end
            lvl = int'(hdr_level[u]);
            hdr_used[u] = 1'b0;
            while (lvl < 7)
            begin
                b = u ^ (1 << lvl);
                if (hdr_used[b] || int'(hdr_level[b]) != lvl)
                    break;
                list_unlink(b, lvl);
                hdr_used[b] = 1'b0;
                if (b < u)
                    u = b;
                lvl++;
            end
            list_push(u, lvl);
        end
    endfunction

    // a free is legal when its header unit has been written
    function automatic bit free_ok(logic [14:0] fa_in);
        int s;
        if (int'(fa_in) < HDR)
            return 1;
        s = int'(fa_in) - HDR;
        if (s % 16 != 0)
            return 1;
        return hdr_known[(s >> 4) & 32'h7FF];
    endfunction

    task automatic send(input logic o, input logic [15:0] req, input logic [14:0] fa_in,
                        input bit chk, input logic [14:0] ea, input logic [1:0] es);
        logic [14:0] pa;
        logic [1:0]  ps;
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        heap_step(o, req, fa_in, pa, ps);
        if (chk && (pa !== ea || ps !== es))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees: op=%0d exp %h/%0d model %h/%0d",
                         o, ea, es, pa, ps);
        end
        if (o == bau_pkg::OP_ALLOC && ps == bau_pkg::ST_OK)
            live_blocks.push_back(pa);
        expected_addr.push_back(pa);
        expected_status.push_back(ps);
        in_valid <= 1'b1;
        op <= o;
        request_bytes <= req;
        free_address <= fa_in;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_addr.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("buddy_allocator_unit_test: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_addr.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h/%0d", address, status);
            end
            else
            begin
                if (address !== expected_addr[0] || status !== expected_status[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp %h/%0d got %h/%0d",
                                 expected_addr[0], expected_status[0], address, status);
                end
                void'(expected_addr.pop_front());
                void'(expected_status.pop_front());
            end
        end
    end

    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (calm)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 15);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    row_t table_rows[$];
    row_t r;
    logic [14:0] free_pick;
    int k;
    int pick;

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = bau_pkg::OP_ALLOC;
        request_bytes = '0;
        free_address = '0;
        mismatches = 0;
        calm = 0;
        chunk_count = 0;
        for (int i = 0; i < bau_pkg::UNITS; i++)
        begin
            hdr_known[i] = 1'b0;
            hdr_used[i] = 1'b0;
            hdr_level[i] = '0;
            link_next[i] = '0;
            link_prev[i] = '0;
        end
        for (int i = 0; i < bau_pkg::LEVELS; i++)
            free_head[i] = bau_pkg::NIL;

        table_rows = '{
            '{bau_pkg::OP_FREE,  16'd0,    15'd5,    1'b1, 15'd0,    bau_pkg::ST_DOUBLE_FREE},
            '{bau_pkg::OP_ALLOC, 16'd0,    15'd0,    1'b1, 15'd12,   bau_pkg::ST_OK},
            '{bau_pkg::OP_ALLOC, 16'hFFFF, 15'd0,    1'b1, 15'd0,    bau_pkg::ST_TOO_LARGE},
            '{bau_pkg::OP_ALLOC, 16'd2037, 15'd0,    1'b1, 15'd0,    bau_pkg::ST_TOO_LARGE},
            '{bau_pkg::OP_ALLOC, 16'd2036, 15'd0,    1'b1, 15'd2060, bau_pkg::ST_OK},
            '{bau_pkg::OP_ALLOC, 16'd4,    15'd0,    1'b0, 15'd0,    bau_pkg::ST_OK},
            '{bau_pkg::OP_ALLOC, 16'd5,    15'd0,    1'b0, 15'd0,    bau_pkg::ST_OK},
            '{bau_pkg::OP_ALLOC, 16'd500,  15'd0,    1'b0, 15'd0,    bau_pkg::ST_OK},
            '{bau_pkg::OP_FREE,  16'd0,    15'd12,   1'b1, 15'd0,    bau_pkg::ST_OK},
            '{bau_pkg::OP_FREE,  16'd0,    15'd12,   1'b1, 15'd0,    bau_pkg::ST_DOUBLE_FREE},
            '{bau_pkg::OP_FREE,  16'd0,    15'd13,   1'b1, 15'd0,    bau_pkg::ST_DOUBLE_FREE},
            '{bau_pkg::OP_FREE,  16'd0,    15'd2060, 1'b1, 15'd0,    bau_pkg::ST_OK},
            '{bau_pkg::OP_FREE,  16'd0,    15'h7FFF, 1'b1, 15'd0,    bau_pkg::ST_DOUBLE_FREE},
            '{bau_pkg::OP_ALLOC, 16'd1000, 15'd0,    1'b0, 15'd0,    bau_pkg::ST_OK}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
        begin
            r = table_rows[i];
            if (r.op == bau_pkg::OP_ALLOC || free_ok(r.addr))
                send(r.op, r.req, r.addr, r.chk, r.exp_addr, r.exp_status);
        end
        // exhaust the heap with full-chunk requests
        for (k = 0; k < 18; k++)
            send(bau_pkg::OP_ALLOC, 16'd2036, '0, 0, '0, '0);
        // pause until every result is back
        drain();
        // stale pointers into merged blocks
        while (live_blocks.size() > 0)
        begin
            pick = $urandom_range(0, live_blocks.size() - 1);
            free_pick = live_blocks[pick];
            live_blocks.delete(pick);
            send(bau_pkg::OP_FREE, '0, free_pick, 0, '0, '0);
        end

        for (k = 0; k < NUM_RANDOM; k++)
        begin
            if (k > NUM_RANDOM - 80)
                calm = 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    send(bau_pkg::OP_ALLOC, 16'($urandom_range(0, 300)), 15'($urandom),
                         0, '0, '0);
                4:
                    send(bau_pkg::OP_ALLOC, 16'($urandom), 15'($urandom), 0, '0, '0);
                5, 6, 7, 8:
                    if (live_blocks.size() > 0)
                    begin
                        pick = $urandom_range(0, live_blocks.size() - 1);
                        free_pick = live_blocks[pick];
                        if ($urandom_range(0, 3) != 0)
                            live_blocks.delete(pick);
                        send(bau_pkg::OP_FREE, 16'($urandom), free_pick, 0, '0, '0);
                    end
                default:
                begin
                    free_pick = 15'($urandom);
                    if (free_ok(free_pick))
                        send(bau_pkg::OP_FREE, 16'($urandom), free_pick, 0, '0, '0);
                end
            endcase
        end

        drain();
        if (mismatches == 0)
            $display("buddy_allocator_unit_test: done, clean");
        else
            $display("buddy_allocator_unit_test: done, errors");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+src
src/bau_pkg.sv
src/bau_ram.sv
src/buddy_allocator_unit.sv
tb/buddy_allocator_unit_test.sv
